// ===== rtl/core/scancode_to_ascii_fifo_macros.svh =====
// Assertion macros for the keyboard translator RTL, used by scta_fifo
`ifndef SCANCODE_TO_ASCII_FIFO_MACROS_SVH
`define SCANCODE_TO_ASCII_FIFO_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCTA_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SCTA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/core/scta_pkg.sv =====
`default_nettype none

package scta_pkg;

   localparam int DEFAULT_FIFO_DEPTH = 16;
   localparam int CHAR_W             = 7;
   localparam int SC_W               = 8;
   localparam int MAP_SIZE           = 58;
   localparam int MAP_IDX_W          = 6;

   // command codes
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // set-1 scancodes with special meaning
   localparam logic [SC_W-1:0] SC_LSHIFT     = 8'h2A;
   localparam logic [SC_W-1:0] SC_RSHIFT     = 8'h36;
   localparam logic [SC_W-1:0] SC_LSHIFT_REL = 8'hAA;
   localparam logic [SC_W-1:0] SC_RSHIFT_REL = 8'hB6;
   localparam logic [SC_W-1:0] SC_CTRL       = 8'h1D;
   localparam logic [SC_W-1:0] SC_CTRL_REL   = 8'h9D;
   localparam logic [SC_W-1:0] SC_ESCAPE     = 8'h01;

   // US layout, unshifted
   localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_SIZE] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   // US layout, shift held
   localparam logic [CHAR_W-1:0] SHIFT_MAP [MAP_SIZE] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   typedef struct packed {
      logic              push;
      logic [CHAR_W-1:0] ch;
   } push_req_type;

   typedef struct packed {
      logic shift;
      logic ctrl;
      logic esc;
   } mod_flags_type;

endpackage

`default_nettype wire

// ===== rtl/core/scancode_to_ascii_fifo.sv =====
// Set-1 keyboard scancode to US ASCII translator with a character queue.
// Request channel: drive req_cmd and req_scancode with start high; the word
//   is taken on a rising edge where start is high and busy is low. req_cmd
//   low carries a scancode byte, high asks for one queued character.
// Response channel: each request gives exactly one response, shown on the
//   rsp_ ports for one cycle with rsp_strobe high. There is no back-pressure:
//   the receiver must take it in that cycle.
// An accepted request goes from the request register through the response
//   register to rsp_strobe; while busy is low a new request can be taken every
//   cycle, as the table lookup and the pointer update both fit between them,
//   and the store read is the one registered port of the character RAM.
// Queue holds FIFO_DEPTH-1 characters; on overflow the character is lost and
//   rsp_dropped is raised. Popping an empty queue returns 0 with
//   rsp_char_valid low.
// Reset (synchronous) clears the modifier flags, escape flag and queue
//   pointers; busy is high while reset is held and the cycle after.
`default_nettype none

module scancode_to_ascii_fifo #(
   parameter int FIFO_DEPTH = scta_pkg::DEFAULT_FIFO_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_cmd,
   input  wire logic [scta_pkg::SC_W-1:0]   req_scancode,
   output logic                             rsp_strobe,
   output logic [scta_pkg::CHAR_W-1:0]      rsp_char_out,
   output logic                             rsp_char_valid,
   output logic                             rsp_has_char,
   output logic                             rsp_dropped,
   output logic                             rsp_shift_down,
   output logic                             rsp_ctrl_down,
   output logic                             rsp_escape_seen
);

   import scta_pkg::*;

   logic              busy_ff;
   logic              accept;
   logic              item_valid_ff;
   logic              cmd_ff;
   logic [SC_W-1:0]   scancode_ff;
   push_req_type      push_req;
   mod_flags_type     flags_next;
   logic              pop;
   logic              pop_ok, has_char, drop;
   logic [CHAR_W-1:0] rd_char;
   logic              strobe_ff, char_valid_ff, has_char_ff, dropped_ff;
   logic              shift_ff, ctrl_ff, esc_ff;

   assign busy   = busy_ff || reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
      if (accept) begin
         cmd_ff      <= req_cmd;
         scancode_ff <= req_scancode;
      end
   end

   assign pop = item_valid_ff && (cmd_ff == CMD_POP);

   scta_xlate u_xlate (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .cmd        (cmd_ff),
      .scancode   (scancode_ff),
      .push_req   (push_req),
      .flags_next (flags_next)
   );

   scta_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .push_req (push_req),
      .pop_ok   (pop_ok),
      .has_char (has_char),
      .drop     (drop),
      .rd_char  (rd_char)
   );

   // response register; character arrives from the store's read register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= item_valid_ff;
      end
      char_valid_ff <= pop_ok;
      has_char_ff   <= has_char;
      dropped_ff    <= drop;
      shift_ff      <= flags_next.shift;
      ctrl_ff       <= flags_next.ctrl;
      esc_ff        <= flags_next.esc;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_char_out    = char_valid_ff ? rd_char : '0;
   assign rsp_char_valid  = char_valid_ff;
   assign rsp_has_char    = has_char_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_shift_down  = shift_ff;
   assign rsp_ctrl_down   = ctrl_ff;
   assign rsp_escape_seen = esc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/scta_ram.sv =====
`default_nettype none

module scta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/scta_xlate.sv =====
`default_nettype none

module scta_xlate (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   input  wire logic                       cmd,
   input  wire logic [scta_pkg::SC_W-1:0]  scancode,
   output scta_pkg::push_req_type          push_req,
   output scta_pkg::mod_flags_type         flags_next
);

   import scta_pkg::*;

   logic                 shift_ff, shift_in;
   logic                 ctrl_ff, ctrl_in;
   logic                 esc_ff, esc_in;
   logic [MAP_IDX_W-1:0] map_idx;
   logic                 is_make_key;
   logic [CHAR_W-1:0]    map_char;

   // table lookup; shift state before this word selects the table
   assign map_idx     = scancode[MAP_IDX_W-1:0];
   assign is_make_key = (scancode < SC_W'(MAP_SIZE));
   assign map_char    = !is_make_key ? '0 :
                        shift_ff ? SHIFT_MAP[map_idx] : PLAIN_MAP[map_idx];

   // scancode decode
   always_comb begin
      shift_in      = shift_ff;
      ctrl_in       = ctrl_ff;
      esc_in        = esc_ff;
      push_req.push = 1'b0;
      push_req.ch   = map_char;
      if (item_valid && cmd == CMD_SCAN) begin
         unique case (scancode) inside
            SC_LSHIFT, SC_RSHIFT:         shift_in = 1'b1;
            SC_LSHIFT_REL, SC_RSHIFT_REL: shift_in = 1'b0;
            SC_CTRL:                      ctrl_in  = 1'b1;
            SC_CTRL_REL:                  ctrl_in  = 1'b0;
            SC_ESCAPE:                    esc_in   = 1'b1;
            default:                      push_req.push = (map_char != '0);
         endcase
      end
   end

   // modifier flags
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         esc_ff   <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         esc_ff   <= esc_in;
      end
   end

   assign flags_next.shift = shift_in;
   assign flags_next.ctrl  = ctrl_in;
   assign flags_next.esc   = esc_in;

endmodule

`default_nettype wire

// ===== rtl/core/scta_fifo.sv =====
`default_nettype none

`include "scancode_to_ascii_fifo_macros.svh"

module scta_fifo #(
   parameter int FIFO_DEPTH = scta_pkg::DEFAULT_FIFO_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         pop,
   input  wire scta_pkg::push_req_type       push_req,
   output logic                              pop_ok,
   output logic                              has_char,
   output logic                              drop,
   output logic [scta_pkg::CHAR_W-1:0]       rd_char
);

   import scta_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
   logic             empty, full, wr_en;

   // ring pointer increments, wrap at the last slot
   assign wr_ptr_inc = (write_ptr_ff == PTR_LAST) ? '0 : write_ptr_ff + PTR_W'(1);
   assign rd_ptr_inc = (read_ptr_ff == PTR_LAST) ? '0 : read_ptr_ff + PTR_W'(1);

   // one slot always left free
   assign empty  = (write_ptr_ff == read_ptr_ff);
   assign full   = (wr_ptr_inc == read_ptr_ff);
   assign pop_ok = pop && !empty;
   assign wr_en  = push_req.push && !full;
   assign drop   = push_req.push && full;

   assign write_ptr_in = wr_en ? wr_ptr_inc : write_ptr_ff;
   assign read_ptr_in  = pop_ok ? rd_ptr_inc : read_ptr_ff;
   assign has_char     = (write_ptr_in != read_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
      end
   end

   // character store; read and write never hit the same slot
   scta_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_ptr_ff),
      .wr_data (push_req.ch),
      .rd_en   (pop_ok),
      .rd_addr (read_ptr_ff),
      .rd_data (rd_char)
   );

   `SCTA_ASSERT_NOW(a_drop_no_write, clock, reset, drop, !wr_en, "dropped word was written")
   `SCTA_ASSERT_NOW(a_no_overrun, clock, reset, wr_en, wr_ptr_inc != read_ptr_ff, "overrun")
   `SCTA_ASSERT_NEXT(a_empty_pop_hold, clock, reset, pop && empty,
                     $stable(read_ptr_ff), "empty pop moved read pointer")
   `SCTA_ASSERT_NOW(a_no_rw_clash, clock, reset, wr_en && pop_ok, 1'b0, "push and pop together")

endmodule

`default_nettype wire

// ===== verif/scancode_to_ascii_fifo_test.sv =====
`timescale 1ns / 100ps

module scancode_to_ascii_fifo_test;
   import scta_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int STALL_LIMIT = 1000;

   // US layout, unshifted and with shift held; zero means no character
   localparam logic [6:0] PLAIN_KEYS [58] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };
   localparam logic [6:0] SHIFTED_KEYS [58] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   typedef struct packed {
      logic [6:0] ch;
      logic       valid;
      logic       has_char;
      logic       dropped;
      logic       shift;
      logic       ctrl;
      logic       esc;
   } key_report_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             req_cmd = CMD_SCAN;
   logic [SC_W-1:0]  req_scancode = '0;
   logic             busy;
   logic             rsp_strobe;
   logic [CHAR_W-1:0] rsp_char_out;
   logic             rsp_char_valid;
   logic             rsp_has_char;
   logic             rsp_dropped;
   logic             rsp_shift_down;
   logic             rsp_ctrl_down;
   logic             rsp_escape_seen;

   // model of the translator state
   logic [6:0]  typed_chars [$];
   logic        shift_held = 1'b0;
   logic        ctrl_held = 1'b0;
   logic        escape_latched = 1'b0;
   key_report_type reports_due [$];

   int  fail_count = 0;
   int  stall_cycles = 0;
   bit  gaps_on = 1'b1;

   scancode_to_ascii_fifo #(.FIFO_DEPTH(QUEUE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_scancode    (req_scancode),
      .rsp_strobe      (rsp_strobe),
      .rsp_char_out    (rsp_char_out),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_has_char    (rsp_has_char),
      .rsp_dropped     (rsp_dropped),
      .rsp_shift_down  (rsp_shift_down),
      .rsp_ctrl_down   (rsp_ctrl_down),
      .rsp_escape_seen (rsp_escape_seen)
   );

   always #6 clock = ~clock;

   // apply one accepted word to the model and queue the report it gives
   function automatic void translate_word(input logic cmd, input logic [7:0] sc);
      key_report_type rep;
      logic [6:0]  ch;
      rep = '0;
      if (cmd == CMD_POP) begin
         if (typed_chars.size() != 0) begin
            rep.ch = typed_chars.pop_front();
            rep.valid = 1'b1;
         end
      end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
         shift_held = 1'b1;
      end else if (sc == SC_LSHIFT_REL || sc == SC_RSHIFT_REL) begin
         shift_held = 1'b0;
      end else if (sc == SC_CTRL) begin
         ctrl_held = 1'b1;
      end else if (sc == SC_CTRL_REL) begin
         ctrl_held = 1'b0;
      end else if (sc == SC_ESCAPE) begin
         escape_latched = 1'b1;
      end else if (!sc[7] && sc < MAP_SIZE) begin
         ch = shift_held ? SHIFTED_KEYS[sc] : PLAIN_KEYS[sc];
         // one slot always stays free
         if (ch != 0) begin
            if (typed_chars.size() < QUEUE_DEPTH - 1)
               typed_chars.push_back(ch);
            else
               rep.dropped = 1'b1;
         end
      end
      rep.has_char = (typed_chars.size() != 0);
      rep.shift = shift_held;
      rep.ctrl = ctrl_held;
      rep.esc = escape_latched;
      reports_due.push_back(rep);
   endfunction

   // printable make code that always maps to a character
   function automatic logic [7:0] pick_key();
      logic [7:0] sc;
      do
         sc = 8'($urandom_range(0, MAP_SIZE - 1));
      while (PLAIN_KEYS[sc] == 0 || sc == SC_ESCAPE);
      return sc;
   endfunction

   // drive one word, with an optional idle burst ahead of it
   task automatic send_word(input logic cmd, input logic [7:0] sc);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
            req_scancode <= 8'($urandom);
         end
      end
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_scancode <= sc;
      do @(posedge clock); while (busy !== 1'b0);
      translate_word(cmd, sc);
   endtask

   // hold off until every outstanding report has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   // compare each response word with the oldest report due
   always @(posedge clock) begin
      key_report_type due;
      if (reset == 1'b0 && rsp_strobe === 1'b1) begin
         if (reports_due.size() == 0) begin
            $error("response word with no request outstanding");
            fail_count++;
         end else begin
            due = reports_due.pop_front();
            check_field("char_out", {1'b0, due.ch}, {1'b0, rsp_char_out});
            check_field("char_valid", {7'b0, due.valid}, {7'b0, rsp_char_valid});
            check_field("has_char", {7'b0, due.has_char}, {7'b0, rsp_has_char});
            check_field("dropped", {7'b0, due.dropped}, {7'b0, rsp_dropped});
            check_field("shift_down", {7'b0, due.shift}, {7'b0, rsp_shift_down});
            check_field("ctrl_down", {7'b0, due.ctrl}, {7'b0, rsp_ctrl_down});
            check_field("escape_seen", {7'b0, due.esc}, {7'b0, rsp_escape_seen});
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("scancode_to_ascii_fifo_test: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // pops on the empty queue straight after reset, scancode field at both extremes
   task automatic test_empty_pop();
      send_word(CMD_POP, 8'h00);
      send_word(CMD_POP, 8'hFF);
   endtask

   // shift, ctrl and escape, with keys typed under shift and ctrl
   task automatic test_modifier_keys();
      send_word(CMD_SCAN, SC_CTRL);
      send_word(CMD_SCAN, 8'h10);        // ctrl leaves the translation alone
      send_word(CMD_SCAN, SC_CTRL_REL);
      send_word(CMD_SCAN, SC_LSHIFT);
      send_word(CMD_SCAN, 8'h02);
      send_word(CMD_SCAN, SC_LSHIFT_REL);
      send_word(CMD_SCAN, SC_RSHIFT);
      send_word(CMD_SCAN, 8'h1A);
      send_word(CMD_SCAN, SC_RSHIFT_REL);
      send_word(CMD_SCAN, SC_ESCAPE);    // sets the flag, queues nothing
      send_word(CMD_SCAN, 8'h81);        // escape release is ignored
   endtask

   // table ends, zero entries, codes past the table and plain releases
   task automatic test_table_edges();
      send_word(CMD_SCAN, 8'h00);
      send_word(CMD_SCAN, 8'h39);
      send_word(CMD_SCAN, 8'h3A);
      send_word(CMD_SCAN, 8'h7F);
      send_word(CMD_SCAN, 8'h80);
      send_word(CMD_SCAN, 8'hFF);
      send_word(CMD_SCAN, 8'h0E);
      repeat (6) send_word(CMD_POP, 8'($urandom));
   endtask

   // fill to capacity, overflow, then drain past empty
   task automatic test_queue_full();
      int n;
      n = typed_chars.size();
      repeat (n) send_word(CMD_POP, 8'($urandom));
      while (typed_chars.size() < QUEUE_DEPTH - 1) begin
         if ($urandom_range(0, 7) == 0)
            send_word(CMD_SCAN, $urandom_range(0, 1) ? SC_LSHIFT : SC_LSHIFT_REL);
         else
            send_word(CMD_SCAN, pick_key());
      end
      repeat (3) send_word(CMD_SCAN, pick_key());
      wait_drained();
      repeat (QUEUE_DEPTH + 1) send_word(CMD_POP, 8'($urandom));
   endtask

   // typing runs with random pop pressure so the queue level wanders
   task automatic test_random_typing(input int target);
      int          counted;
      int          pop_pct;
      int          run;
      int          pick;
      logic        cmd;
      logic [7:0]  sc;
      counted = 0;
      while (counted < target) begin
         pop_pct = $urandom_range(5, 60);
         run = $urandom_range(10, 40);
         repeat (run) begin
            sc = 8'($urandom);
            cmd = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_SCAN;
            if (cmd == CMD_SCAN) begin
               pick = $urandom_range(0, 99);
               if (pick < 60)
                  sc = 8'($urandom_range(0, MAP_SIZE - 1));
               else if (pick < 72)
                  case ($urandom_range(0, 3))
                     0: sc = SC_LSHIFT;
                     1: sc = SC_RSHIFT;
                     2: sc = SC_LSHIFT_REL;
                     default: sc = SC_RSHIFT_REL;
                  endcase
               else if (pick < 80)
                  sc = $urandom_range(0, 1) ? SC_CTRL : SC_CTRL_REL;
               else if (pick < 82)
                  sc = SC_ESCAPE;
               else if (pick < 90)
                  sc = {1'b1, 7'($urandom_range(0, MAP_SIZE - 1))};
            end
            send_word(cmd, sc);
            // plain release codes do nothing and are not counted
            if (!(cmd == CMD_SCAN && sc[7] && sc != SC_LSHIFT_REL &&
                  sc != SC_RSHIFT_REL && sc != SC_CTRL_REL))
               counted++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pop();
      test_modifier_keys();
      test_table_edges();
      test_queue_full();
      test_random_typing(380);
      // back-to-back words to finish
      gaps_on = 1'b0;
      test_random_typing(40);

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("scancode_to_ascii_fifo_test: PASS");
      else
         $display("scancode_to_ascii_fifo_test: FAIL");
      $finish;
   end

endmodule
